// ===== rtl/core/adc_sample_filter_to_millivolts_assert.svh =====
// -----------------------------------------------------------------------------
// ADC sample filter assertion macros
// Property macros used by the filter file that carries assertions.
// -----------------------------------------------------------------------------
`ifndef ADC_SAMPLE_FILTER_TO_MILLIVOLTS_ASSERT_SVH
`define ADC_SAMPLE_FILTER_TO_MILLIVOLTS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASFM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASFM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/asfm_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ADC sample filter package
// Shared constants, register codes, state type and reference table.
// -----------------------------------------------------------------------------
package asfm_pkg;

   localparam int MAX_WINDOW_DEF      = 16;
   localparam int SAMPLE_BITS_DEF     = 12;
   localparam int ALPHA_FRAC_BITS_DEF = 10;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int MODE_W      = 2;
   localparam int COUNT_W     = 5;
   localparam int ALPHA_W     = 11;
   localparam int OFFSET_W    = 13;
   localparam int RES_W       = 4;
   localparam int ATTEN_W     = 2;
   localparam int VREF_W      = 12;
   localparam int MV_W        = 12;
   localparam int MV_MAX      = 3300;
   localparam int RES_MIN     = 9;

   typedef enum logic [MODE_W-1:0] {
      MODE_PASS   = 2'd0,
      MODE_AVG    = 2'd1,
      MODE_MEDIAN = 2'd2,
      MODE_EMA    = 2'd3
   } filter_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_MODE   = 3'd0,
      CSR_WINDOW_COUNT  = 3'd1,
      CSR_EMA_ALPHA     = 3'd2,
      CSR_SAMPLE_OFFSET = 3'd3,
      CSR_RESOLUTION    = 3'd4,
      CSR_ATTENUATION   = 3'd5
   } csr_index_type;

   localparam filter_mode_type         MODE_RST   = MODE_PASS;
   localparam logic [COUNT_W-1:0]      COUNT_RST  = 5'd10;
   localparam logic [ALPHA_W-1:0]      ALPHA_RST  = 11'd307;
   localparam logic [OFFSET_W-1:0]     OFFSET_RST = '0;
   localparam logic [RES_W-1:0]        RES_RST    = 4'd12;
   localparam logic [ATTEN_W-1:0]      ATTEN_RST  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMA_MUL,
      ST_EMA_ADD,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_MED_READ,
      ST_MV_MUL,
      ST_MV_GO,
      ST_MV_WAIT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [VREF_W-1:0] vref_mv(input logic [ATTEN_W-1:0] att);
      logic [VREF_W-1:0] v;
      case (att)
         2'd0:    v = 12'd1100;
         2'd1:    v = 12'd1500;
         2'd2:    v = 12'd2200;
         default: v = 12'd3300;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/adc_sample_filter_to_millivolts.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ADC sample filter to millivolts
// Filters converter samples (pass-through, window average, window median or
// exponential moving average) and scales the result to millivolts.
// -----------------------------------------------------------------------------
// The block takes one request per converter sample and works on one request at
// a time. A window sample that does not complete its window is absorbed while
// the sequencer stays idle, so the next request is taken straight away; a seed
// request for the moving average likewise leaves the sequencer idle and gives
// no result. Every other request passes through the millivolt conversion, which
// runs on a shared bit-serial divider that retires one quotient bit per cycle
// over SAMPLE_BITS + 12 bits. Pass-through goes through the multiply, divider
// start, divider wait and result states; the median first reads the middle
// cell, the moving average first passes its multiply and add states, and the
// sample that closes an averaging window first sends the window mean through
// the same divider. The divider therefore sets the rate. Window samples are
// kept in a chain of sorting cells, each holding one sample, so the window is
// always in ascending order and the median is simply the middle cell. A finished
// result sits in an output register, so the next request is accepted while the
// previous result waits to be taken. Configuration registers are to be written
// through the csr_ port only while the block is idle; this is not enforced.
// -----------------------------------------------------------------------------
`include "adc_sample_filter_to_millivolts_assert.svh"

module adc_sample_filter_to_millivolts #(
   parameter int MAX_WINDOW      = asfm_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS     = asfm_pkg::SAMPLE_BITS_DEF,
   parameter int ALPHA_FRAC_BITS = asfm_pkg::ALPHA_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [SAMPLE_BITS-1:0]           req_sample_value,
   input  logic                             req_seed_ema,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [SAMPLE_BITS-1:0]           rsp_filtered_raw,
   output logic [asfm_pkg::MV_W-1:0]        rsp_millivolts,
   // Configuration write port
   input  logic                             csr_we,
   input  logic [asfm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [asfm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import asfm_pkg::*;

   // Derived widths.
   localparam int FILL_W = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W  = SAMPLE_BITS + FILL_W;
   localparam int LVL_W  = SAMPLE_BITS + ALPHA_FRAC_BITS;
   localparam int AW     = ALPHA_FRAC_BITS + 1;
   localparam int P1_W   = AW + SAMPLE_BITS;
   localparam int P2_W   = AW + LVL_W;
   localparam int DIV_W  = SAMPLE_BITS + VREF_W;
   localparam int DVS_W  = SAMPLE_BITS;
   localparam int ADJ_W  = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 2;

   localparam logic [AW-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};

   // Configuration registers.
   filter_mode_type             mode_ff;
   logic [COUNT_W-1:0]          count_ff;
   logic [ALPHA_W-1:0]          alpha_ff;
   logic signed [OFFSET_W-1:0]  offset_ff;
   logic [RES_W-1:0]            res_ff;
   logic [ATTEN_W-1:0]          atten_ff;

   // Sequencer and filter state.
   state_type                   state_ff, state_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic [LVL_W-1:0]            ema_ff, ema_in;
   logic [SAMPLE_BITS-1:0]      filt_ff, filt_in;
   logic [DIV_W-1:0]            op_ff, op_in;
   logic [DVS_W-1:0]            dvs_ff, dvs_in;
   logic [P1_W-1:0]             p1_ff, p1_in;
   logic [P2_W-1:0]             p2_ff, p2_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]      rsp_raw_ff, rsp_raw_in;
   logic [MV_W-1:0]             rsp_mv_ff, rsp_mv_in;

   // Working values.
   logic                        acc;
   logic                        win_mode;
   logic [FILL_W-1:0]           n_eff;
   logic [FILL_W-1:0]           fill_eff;
   logic [FILL_W-1:0]           fill_new;
   logic [SUM_W-1:0]            sum_new;
   logic                        win_done;
   logic                        win_step;
   logic [IDX_W-1:0]            mid;
   logic                        cell_ins;
   logic [AW-1:0]               a_eff;
   logic [LVL_W:0]              lvl_sum;
   logic [4:0]                  bits_eff;
   logic [SAMPLE_BITS-1:0]      maxv;
   logic signed [ADJ_W-1:0]     adj_s;
   logic [SAMPLE_BITS-1:0]      adj_c;
   logic                        div_start;
   logic [DIV_W-1:0]            div_quot;
   div_stat_type                div_stat;

   logic [SAMPLE_BITS-1:0]      cell_val  [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0]      left_val  [MAX_WINDOW];
   logic                        cell_gt   [MAX_WINDOW];
   logic                        left_gt   [MAX_WINDOW];

   // --------------------------------------------------------------------------
   // Configuration registers
   // --------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RST;
         count_ff  <= COUNT_RST;
         alpha_ff  <= ALPHA_RST;
         offset_ff <= OFFSET_RST;
         res_ff    <= RES_RST;
         atten_ff  <= ATTEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FILTER_MODE:   mode_ff   <= filter_mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_WINDOW_COUNT:  count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_EMA_ALPHA:     alpha_ff  <= csr_wdata[ALPHA_W-1:0];
            CSR_SAMPLE_OFFSET: offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_RESOLUTION:    res_ff    <= csr_wdata[RES_W-1:0];
            CSR_ATTENUATION:   atten_ff  <= csr_wdata[ATTEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // Window bookkeeping, moving average and conversion arithmetic
   // --------------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);
   assign acc       = req_valid && req_ready;

   always_comb begin
      win_mode = mode_ff inside {MODE_AVG, MODE_MEDIAN};

      // A window count of zero behaves as one; large counts saturate.
      if (count_ff == '0) begin
         n_eff = FILL_W'(1);
      end else if (32'(count_ff) > MAX_WINDOW) begin
         n_eff = FILL_W'(MAX_WINDOW);
      end else begin
         n_eff = FILL_W'(count_ff);
      end

      // A window left over from a larger count starts again empty.
      if (fill_ff >= n_eff) begin
         fill_eff = '0;
         sum_new  = SUM_W'(req_sample_value);
      end else begin
         fill_eff = fill_ff;
         sum_new  = sum_ff + SUM_W'(req_sample_value);
      end
      fill_new = fill_eff + FILL_W'(1);
      win_done = (fill_new >= n_eff);
      win_step = acc && !req_seed_ema && win_mode && !win_done;
      mid      = IDX_W'(n_eff >> 1);

      if (32'(alpha_ff) > 32'(ALPHA_ONE)) begin
         a_eff = ALPHA_ONE;
      end else begin
         a_eff = AW'(alpha_ff);
      end
      // The new sample term is a whole multiple of one, so only the old level
      // term loses its fraction bits.
      lvl_sum = p1_ff + p2_ff[P2_W-1:ALPHA_FRAC_BITS];

      if (res_ff < RES_W'(RES_MIN)) begin
         bits_eff = 5'(RES_MIN);
      end else if (32'(res_ff) > SAMPLE_BITS) begin
         bits_eff = 5'(SAMPLE_BITS);
      end else begin
         bits_eff = 5'(res_ff);
      end
      maxv  = ~({SAMPLE_BITS{1'b1}} << bits_eff);
      adj_s = $signed(ADJ_W'(filt_ff)) + ADJ_W'(offset_ff);
      if (adj_s < 0) begin
         adj_c = '0;
      end else if (adj_s > $signed(ADJ_W'(maxv))) begin
         adj_c = maxv;
      end else begin
         adj_c = adj_s[SAMPLE_BITS-1:0];
      end
   end

   // --------------------------------------------------------------------------
   // Sequencer: next state
   // --------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc && !req_seed_ema) begin
               case (mode_ff)
                  MODE_PASS:   state_in = ST_MV_MUL;
                  MODE_EMA:    state_in = ST_EMA_MUL;
                  MODE_AVG:    state_in = win_done ? ST_AVG_GO : ST_IDLE;
                  MODE_MEDIAN: state_in = win_done ? ST_MED_READ : ST_IDLE;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_EMA_MUL:  state_in = ST_EMA_ADD;
         ST_EMA_ADD:  state_in = ST_MV_MUL;
         ST_AVG_GO:   state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: state_in = div_stat.done ? ST_MV_MUL : ST_AVG_WAIT;
         ST_MED_READ: state_in = ST_MV_MUL;
         ST_MV_MUL:   state_in = ST_MV_GO;
         ST_MV_GO:    state_in = ST_MV_WAIT;
         ST_MV_WAIT:  state_in = div_stat.done ? ST_RESULT : ST_MV_WAIT;
         ST_RESULT:   state_in = (!rsp_valid_ff || rsp_ready) ? ST_IDLE : ST_RESULT;
         default:     state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------------------
   // Sequencer: datapath controls and register loads
   // --------------------------------------------------------------------------
   always_comb begin
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      ema_in       = ema_ff;
      filt_in      = filt_ff;
      op_in        = op_ff;
      dvs_in       = dvs_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_raw_in   = rsp_raw_ff;
      rsp_mv_in    = rsp_mv_ff;
      cell_ins     = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (acc && req_seed_ema) begin
               ema_in = {req_sample_value, {ALPHA_FRAC_BITS{1'b0}}};
            end else if (acc) begin
               case (mode_ff)
                  MODE_PASS: begin
                     filt_in = req_sample_value;
                  end
                  MODE_EMA: begin
                     p1_in = P1_W'(a_eff) * P1_W'(req_sample_value);
                     p2_in = P2_W'(ALPHA_ONE - a_eff) * P2_W'(ema_ff);
                  end
                  MODE_AVG, MODE_MEDIAN: begin
                     cell_ins = 1'b1;
                     if (win_done) begin
                        fill_in = '0;
                        sum_in  = '0;
                        op_in   = DIV_W'(sum_new);
                        dvs_in  = DVS_W'(n_eff);
                     end else begin
                        fill_in = fill_new;
                        sum_in  = sum_new;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EMA_ADD: begin
            ema_in  = lvl_sum[LVL_W-1:0];
            filt_in = lvl_sum[LVL_W-1:ALPHA_FRAC_BITS];
         end
         ST_AVG_GO: begin
            div_start = 1'b1;
         end
         ST_AVG_WAIT: begin
            if (div_stat.done) begin
               filt_in = div_quot[SAMPLE_BITS-1:0];
            end
         end
         ST_MED_READ: begin
            filt_in = cell_val[mid];
         end
         ST_MV_MUL: begin
            op_in  = DIV_W'(adj_c) * DIV_W'(vref_mv(atten_ff));
            dvs_in = maxv;
         end
         ST_MV_GO: begin
            div_start = 1'b1;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_raw_in   = filt_ff;
               rsp_mv_in    = div_quot[MV_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         ema_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         ema_ff       <= ema_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      filt_ff    <= filt_in;
      op_ff      <= op_in;
      dvs_ff     <= dvs_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      rsp_raw_ff <= rsp_raw_in;
      rsp_mv_ff  <= rsp_mv_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_raw = rsp_raw_ff;
   assign rsp_millivolts   = rsp_mv_ff;

   // --------------------------------------------------------------------------
   // Sorting chain: each new sample is inserted in order, larger samples move
   // one cell to the right.
   // --------------------------------------------------------------------------
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_val[i] = '0;
         assign left_gt[i]  = 1'b0;
      end else begin : g_body
         assign left_val[i] = cell_val[i-1];
         assign left_gt[i]  = cell_gt[i-1];
      end

      asfm_sort_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .FILL_W      (FILL_W),
         .IDX         (i)
      ) u_cell (
         .clock    (clock),
         .ins      (cell_ins),
         .fill     (fill_eff),
         .sample   (req_sample_value),
         .left_val (left_val[i]),
         .left_gt  (left_gt[i]),
         .val      (cell_val[i]),
         .gt       (cell_gt[i])
      );
   end

   // --------------------------------------------------------------------------
   // Shared divider for the window mean and the millivolt scaling.
   // --------------------------------------------------------------------------
   asfm_divider #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (DVS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (op_ff),
      .divisor  (dvs_ff),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   // --------------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------------
   `ASFM_ASSERT_IMPLIES(a_div_start_idle, clock, reset, div_start, !div_stat.busy)
   `ASFM_ASSERT_NEXT(a_fill_grows, clock, reset, win_step, fill_ff == $past(fill_new))
   `ASFM_ASSERT_IMPLIES(a_mv_range, clock, reset, rsp_valid_ff, rsp_mv_ff <= MV_W'(MV_MAX))

endmodule

// ===== rtl/core/asfm_sort_cell.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Sorting cell
// One place of the ascending insertion chain that holds the window samples.
// -----------------------------------------------------------------------------
module asfm_sort_cell #(
   parameter int SAMPLE_BITS = 12,
   parameter int FILL_W      = 5,
   parameter int IDX         = 0
) (
   input  logic                   clock,
   input  logic                   ins,
   input  logic [FILL_W-1:0]      fill,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [SAMPLE_BITS-1:0] left_val,
   input  logic                   left_gt,
   output logic [SAMPLE_BITS-1:0] val,
   output logic                   gt
);

   logic [SAMPLE_BITS-1:0] val_ff;
   logic [SAMPLE_BITS-1:0] val_in;

   // An empty place counts as larger than any sample, so the chain stays sorted.
   always_comb begin
      gt     = (fill <= FILL_W'(IDX)) || (val_ff > sample);
      val_in = left_gt ? left_val : (gt ? sample : val_ff);
   end

   always_ff @(posedge clock) begin
      if (ins) begin
         val_ff <= val_in;
      end
   end

   assign val = val_ff;

endmodule

// ===== rtl/core/asfm_divider.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Shared divider
// Restoring divider that retires one quotient bit per cycle.
// -----------------------------------------------------------------------------
module asfm_divider #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIVIDEND_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]    divisor,
   output logic [DIVIDEND_W-1:0]   quotient,
   output asfm_pkg::div_stat_type  stat
);

   import asfm_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  diff;
   logic                  ge;

   always_comb begin
      shifted = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff    = {1'b0, shifted} - {2'b00, div_ff};
      ge      = ~diff[DIVISOR_W+1];
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
      end else if (cnt_ff != '0) begin
         quot_in = {quot_ff[DIVIDEND_W-2:0], ge};
         rem_in  = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign quotient  = quot_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule
